// File: hw/rtl/rcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the radix converter
// Field widths, character codes, register indexes and the request/response
// structures that pass between the converter's modules.
// ----------------------------------------------------------------------------
package rcf_pkg;

    localparam int CHAR_W          = 8;
    localparam int BASE_W          = 5;
    localparam int INT_W           = 52;
    localparam int NUM_W           = 44;
    localparam int DEN_W           = 45;
    localparam int DIGIT_W         = 4;
    localparam int DIGIT_DEPTH     = 52;
    localparam int OUT_LIMIT       = 57;
    localparam int N_W             = $clog2(OUT_LIMIT + 1);
    localparam int ND_W            = $clog2(DIGIT_DEPTH + 1);
    localparam int DIGIT_AW        = $clog2(DIGIT_DEPTH);
    localparam int STEP_W          = $clog2(INT_W);
    localparam int MAX_CHARS_DEF   = 13;
    localparam int MAX_FRAC_DEF    = 12;

    localparam logic [BASE_W-1:0] BASE_MIN         = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX         = 5'd16;
    localparam logic [BASE_W-1:0] SOURCE_BASE_RST  = 5'd10;
    localparam logic [BASE_W-1:0] TARGET_BASE_RST  = 5'd2;

    localparam logic REG_SOURCE_BASE = 1'b0;
    localparam logic REG_TARGET_BASE = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UA   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF   = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

    typedef struct packed {
        logic             start;
        logic [INT_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [INT_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic             error;
        logic [INT_W-1:0] int_val;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } run_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
            c = CHAR_ZERO + CHAR_W'(d);
        else
            c = CHAR_LA + CHAR_W'(d) - 8'd10;
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rcf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rcf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 52
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/rcf_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_divider: shared restoring divider
// Produces one quotient bit per cycle, one for each dividend bit, and
// done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module rcf_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  rcf_pkg::div_req_t req,
    output rcf_pkg::div_rsp_t rsp
);
    import rcf_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [INT_W-1:0]  dvd_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  dsr_reg;

    logic [DEN_W:0]    partial;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign partial = {rem_reg, dvd_reg[INT_W-1]};
    assign diff    = partial - {1'b0, dsr_reg};
    assign fits    = (partial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(INT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[INT_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

// File: hw/rtl/rcf_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_parser: character checker and accumulator
// Validates each incoming character and folds digits into the integer
// value or the exact fraction numerator and denominator.
// ----------------------------------------------------------------------------
module rcf_parser #(
    parameter int MAX_CHARS = rcf_pkg::MAX_CHARS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        clear,
    input  logic [rcf_pkg::CHAR_W-1:0]  char_code,
    input  logic                        last_char,
    input  logic [rcf_pkg::BASE_W-1:0]  source_base,
    output rcf_pkg::run_t               run
);
    import rcf_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    dot_reg, dot_next;
    logic                    err_reg, err_next;
    logic [INT_W-1:0]        int_reg, int_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;

    logic                    dig_ok;
    logic [DIGIT_W-1:0]      dig;
    logic [INT_W+BASE_W-1:0] int_prod;
    logic [NUM_W+BASE_W-1:0] num_prod;
    logic [DEN_W+BASE_W-1:0] den_prod;

    always_comb
    begin
        dig_ok = 1'b1;
        dig    = '0;
        if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
            dig = DIGIT_W'(char_code - CHAR_ZERO);
        else if (char_code >= CHAR_LA && char_code <= CHAR_LF)
            dig = DIGIT_W'(char_code - CHAR_LA + 8'd10);
        else if (char_code >= CHAR_UA && char_code <= CHAR_UF)
            dig = DIGIT_W'(char_code - CHAR_UA + 8'd10);
        else
            dig_ok = 1'b0;
    end

    assign int_prod = int_reg * source_base;
    assign num_prod = num_reg * source_base;
    assign den_prod = den_reg * source_base;

    always_comb
    begin
        count_next = count_reg;
        dot_next   = dot_reg;
        err_next   = err_reg;
        int_next   = int_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        if (clear)
        begin
            count_next = '0;
            dot_next   = 1'b0;
            err_next   = 1'b0;
            int_next   = '0;
            num_next   = '0;
            den_next   = DEN_W'(1);
        end
        else if (accept && !err_reg)
        begin
            if (count_reg >= CNT_W'(MAX_CHARS))
            begin
                err_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if (char_code == CHAR_DOT)
                begin
                    // A dot may come only once and never first or last.
                    if (dot_reg || count_reg == '0 || last_char)
                        err_next = 1'b1;
                    else
                        dot_next = 1'b1;
                end
                else if (!dig_ok || {1'b0, dig} >= source_base)
                begin
                    err_next = 1'b1;
                end
                else if (!dot_reg)
                begin
                    int_next = int_prod[INT_W-1:0] + INT_W'(dig);
                end
                else
                begin
                    num_next = num_prod[NUM_W-1:0] + NUM_W'(dig);
                    den_next = den_prod[DEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dot_reg   <= 1'b0;
            err_reg   <= 1'b0;
            int_reg   <= '0;
            num_reg   <= '0;
            den_reg   <= DEN_W'(1);
        end
        else
        begin
            count_reg <= count_next;
            dot_reg   <= dot_next;
            err_reg   <= err_next;
            int_reg   <= int_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
        end
    end

    assign run.error   = err_reg;
    assign run.int_val = int_reg;
    assign run.num     = num_reg;
    assign run.den     = den_reg;

endmodule
`default_nettype wire

// File: hw/rtl/radix_converter_with_fraction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_converter_with_fraction: base conversion of a number with fraction
// Converts an ASCII number in source_base to ASCII digits in target_base.
// ----------------------------------------------------------------------------
// A character request that is not the last is accepted while idle and busy
// stays low. The last character starts the conversion and busy stays high
// until the final result. One shared bit-serial divider does every division:
// each integer digit costs one division plus a read and an emit from the
// digit buffer, the dot its own state, and each fraction digit one division.
// An error result comes in the cycle after the request.
// Results are shown for one cycle each under strobe and cannot be stalled.
// ----------------------------------------------------------------------------
module radix_converter_with_fraction #(
    parameter int MAX_CHARS           = rcf_pkg::MAX_CHARS_DEF,
    parameter int MAX_FRACTION_DIGITS = rcf_pkg::MAX_FRAC_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rcf_pkg::CHAR_W-1:0] char_code,
    input  logic                       last_char,
    output logic                       strobe,
    output logic [rcf_pkg::CHAR_W-1:0] out_char,
    output logic                       bad_input,
    output logic                       last_out,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [rcf_pkg::BASE_W-1:0] cfg_data
);
    import rcf_pkg::*;

    localparam int FD_W = $clog2(MAX_FRACTION_DIGITS + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_INT_DIV  = 3'd2;
    localparam logic [2:0] ST_INT_RD   = 3'd3;
    localparam logic [2:0] ST_INT_EMIT = 3'd4;
    localparam logic [2:0] ST_DOT      = 3'd5;
    localparam logic [2:0] ST_FRAC_DIV = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [BASE_W-1:0]       sb_reg;
    logic [BASE_W-1:0]       tb_reg;
    logic [ND_W-1:0]         nd_reg, nd_next;
    logic [N_W-1:0]          n_reg, n_next;
    logic [FD_W-1:0]         fd_reg, fd_next;
    logic [DEN_W-1:0]        num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;

    run_t                    run;
    logic                    accept;
    logic                    run_clear;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    logic                    ram_we;
    logic [DIGIT_AW-1:0]     ram_raddr;
    logic [DIGIT_W-1:0]      ram_rdata;

    logic                    bases_ok;
    logic                    frac_go;
    logic                    frac_end;
    logic [DEN_W-1:0]        mul_src;
    logic [DEN_W+BASE_W-1:0] frac_prod;
    logic [INT_W-1:0]        frac_dividend;
    logic [ND_W-1:0]         nd_dec;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign bases_ok = (sb_reg >= BASE_MIN) && (sb_reg <= BASE_MAX)
                   && (tb_reg >= BASE_MIN) && (tb_reg <= BASE_MAX);

    // The fraction follows the integer digits only if it is nonzero and
    // there is room left for the dot and at least one digit.
    assign frac_go = (num_reg != '0) && (den_reg != '0)
                  && ((7'(n_reg) + 7'd2) < 7'(OUT_LIMIT));

    assign frac_end = (div_rsp.remainder == '0)
                   || (fd_reg == FD_W'(MAX_FRACTION_DIGITS - 1))
                   || (n_reg == N_W'(OUT_LIMIT - 1));

    assign mul_src       = (state_reg == ST_DOT) ? num_reg : div_rsp.remainder;
    assign frac_prod     = mul_src * tb_reg;
    assign frac_dividend = INT_W'(frac_prod);
    assign nd_dec        = nd_reg - 1'b1;
    assign ram_raddr     = nd_dec[DIGIT_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg <= SOURCE_BASE_RST;
            tb_reg <= TARGET_BASE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_BASE: sb_reg <= cfg_data;
                REG_TARGET_BASE: tb_reg <= cfg_data;
                default:         sb_reg <= sb_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        nd_next          = nd_reg;
        n_next           = n_reg;
        fd_next          = fd_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        run_clear        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = frac_dividend;
        div_req.divisor  = den_reg;
        ram_we           = 1'b0;
        strobe           = 1'b0;
        out_char         = CHAR_NONE;
        bad_input        = 1'b0;
        last_out         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_char)
                    state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                run_clear = 1'b1;
                if (run.error || !bases_ok)
                begin
                    strobe     = 1'b1;
                    bad_input  = 1'b1;
                    last_out   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    num_next         = DEN_W'(run.num);
                    den_next         = run.den;
                    nd_next          = '0;
                    n_next           = '0;
                    div_req.start    = 1'b1;
                    div_req.dividend = run.int_val;
                    div_req.divisor  = DEN_W'(tb_reg);
                    state_next       = ST_INT_DIV;
                end
            end

            ST_INT_DIV:
            begin
                if (div_rsp.done)
                begin
                    ram_we  = 1'b1;
                    nd_next = nd_reg + 1'b1;
                    if (div_rsp.quotient != '0
                        && (nd_reg + 1'b1) < ND_W'(DIGIT_DEPTH))
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = DEN_W'(tb_reg);
                    end
                    else
                    begin
                        state_next = ST_INT_RD;
                    end
                end
            end

            ST_INT_RD:
            begin
                state_next = ST_INT_EMIT;
            end

            ST_INT_EMIT:
            begin
                strobe   = 1'b1;
                out_char = glyph(ram_rdata);
                nd_next  = nd_dec;
                n_next   = n_reg + 1'b1;
                if (nd_reg != ND_W'(1))
                begin
                    state_next = ST_INT_RD;
                end
                else if (frac_go)
                begin
                    state_next = ST_DOT;
                end
                else
                begin
                    last_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DOT:
            begin
                strobe        = 1'b1;
                out_char      = CHAR_DOT;
                n_next        = n_reg + 1'b1;
                fd_next       = '0;
                div_req.start = 1'b1;
                state_next    = ST_FRAC_DIV;
            end

            ST_FRAC_DIV:
            begin
                if (div_rsp.done)
                begin
                    strobe   = 1'b1;
                    out_char = (div_rsp.quotient[INT_W-1:DIGIT_W] == '0)
                             ? glyph(div_rsp.quotient[DIGIT_W-1:0]) : CHAR_ZERO;
                    n_next   = n_reg + 1'b1;
                    fd_next  = fd_reg + 1'b1;
                    num_next = div_rsp.remainder;
                    if (frac_end)
                    begin
                        last_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nd_reg    <= '0;
            n_reg     <= '0;
            fd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nd_reg    <= nd_next;
            n_reg     <= n_next;
            fd_reg    <= fd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
    end

    rcf_parser #(
        .MAX_CHARS (MAX_CHARS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .clear       (run_clear),
        .char_code   (char_code),
        .last_char   (last_char),
        .source_base (sb_reg),
        .run         (run)
    );

    rcf_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rcf_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nd_reg[DIGIT_AW-1:0]),
        .wdata (div_rsp.remainder[DIGIT_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// File: hw/rtl/rcf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_checker: port-level checks of the radix converter
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module rcf_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       last_char,
    input  logic                       strobe,
    input  logic [rcf_pkg::CHAR_W-1:0] out_char,
    input  logic                       bad_input,
    input  logic                       last_out
);
    import rcf_pkg::*;

    // An error result is the single, final result of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && bad_input |-> last_out && out_char == CHAR_NONE)
        else $error("error result is not a lone final result");

    // Results appear only while a conversion runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result shown while idle");

    // The final result frees the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_out |=> !busy)
        else $error("still busy after final result");

    // The last character request starts a conversion at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_char |=> busy)
        else $error("last character did not start a conversion");

    // The block goes idle only by delivering a final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(strobe && last_out))
        else $error("conversion ended without a final result");

endmodule

bind radix_converter_with_fraction rcf_checker u_rcf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last_char (last_char),
    .strobe    (strobe),
    .out_char  (out_char),
    .bad_input (bad_input),
    .last_out  (last_out)
);
`default_nettype wire

// File: tb/tb_radix_converter_with_fraction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_converter_with_fraction: self-checking bench of the radix converter
// Sends ASCII numbers one character per request. These are directed cases
// first, then random well-formed, broken and junk numbers under changing
// bases. A scoreboard converts every accepted number itself and compares
// each output character field by field, in order.
// ----------------------------------------------------------------------------

import rcf_pkg::*;

typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              bad;
    logic              fin;
} converted_char_t;

class radix_scoreboard;
    logic [BASE_W-1:0] source_base = SOURCE_BASE_RST;
    logic [BASE_W-1:0] target_base = TARGET_BASE_RST;
    int                char_count  = 0;
    bit                dot_seen    = 0;
    bit                error_flag  = 0;
    logic [63:0]       int_value   = 0;
    logic [63:0]       frac_num    = 0;
    logic [63:0]       frac_den    = 1;
    converted_char_t   expected_chars[$];
    int                failures    = 0;
    string             glyph_set   = "0123456789abcdef";

    function void write_register(input logic idx, input logic [BASE_W-1:0] value);
        if (idx == REG_SOURCE_BASE)
            source_base = value;
        else
            target_base = value;
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction

    function void clear_number();
        char_count = 0;
        dot_seen   = 0;
        error_flag = 0;
        int_value  = 0;
        frac_num   = 0;
        frac_den   = 1;
    endfunction

    function void take_char(input logic [CHAR_W-1:0] c, input logic last);
        bit first;
        int digit;
        first = (char_count == 0);
        if (char_count >= MAX_CHARS_DEF) begin
            error_flag = 1;
            return;
        end
        char_count++;
        if (c == CHAR_DOT) begin
            if (dot_seen || first || last)
                error_flag = 1;
            else
                dot_seen = 1;
            return;
        end
        digit = -1;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            digit = int'(c - CHAR_ZERO);
        else if (c >= CHAR_LA && c <= CHAR_LF)
            digit = int'(c - CHAR_LA) + 10;
        else if (c >= CHAR_UA && c <= CHAR_UF)
            digit = int'(c - CHAR_UA) + 10;
        if (digit < 0 || digit >= int'(source_base)) begin
            error_flag = 1;
            return;
        end
        if (!dot_seen) begin
            int_value = (int_value * 64'(source_base) + 64'(digit))
                        & ((64'd1 << INT_W) - 64'd1);
        end
        else begin
            frac_num = (frac_num * 64'(source_base) + 64'(digit))
                       & ((64'd1 << NUM_W) - 64'd1);
            frac_den = (frac_den * 64'(source_base)) & ((64'd1 << DEN_W) - 64'd1);
        end
    endfunction

    // Integer digits are produced least significant first and sent out in
    // reverse; the fraction is expanded by long division of num over den.
    function void convert_number();
        logic [3:0]      digits[DIGIT_DEPTH];
        converted_char_t run_out[OUT_LIMIT];
        logic [63:0]     t, v, num, den, q;
        int              nd, n, fd;
        t  = 64'(target_base);
        v  = int_value;
        nd = 0;
        n  = 0;
        do
        begin
            digits[nd] = 4'(v % t);
            nd++;
            v = v / t;
        end
        while (v != 0 && nd < DIGIT_DEPTH);
        while (nd > 0 && n < OUT_LIMIT) begin
            nd--;
            run_out[n] = '{glyph_set[digits[nd]], 1'b0, 1'b0};
            n++;
        end
        num = frac_num;
        den = frac_den;
        if (den != 0 && num != 0 && n + 1 < OUT_LIMIT) begin
            run_out[n] = '{CHAR_DOT, 1'b0, 1'b0};
            n++;
            fd = 0;
            while (num != 0 && fd < MAX_FRAC_DEF && n < OUT_LIMIT) begin
                num = num * t;
                q   = num / den;
                num = num % den;
                run_out[n] = '{(q <= 15) ? glyph_set[q[3:0]] : CHAR_ZERO, 1'b0, 1'b0};
                n++;
                fd++;
            end
        end
        run_out[n-1].fin = 1'b1;
        for (int i = 0; i < n; i++)
            expected_chars.push_back(run_out[i]);
    endfunction

    function void note_char(input logic [CHAR_W-1:0] c, input logic last);
        if (!error_flag)
            take_char(c, last);
        if (last) begin
            if (source_base < BASE_MIN || source_base > BASE_MAX ||
                target_base < BASE_MIN || target_base > BASE_MAX)
                error_flag = 1;
            if (error_flag)
                expected_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
            else
                convert_number();
            clear_number();
        end
    endfunction

    function void report(input string field, input logic [7:0] want, input logic [7:0] got);
        failures++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endfunction

    function void check_result(input logic [CHAR_W-1:0] ch, input logic bad, input logic fin);
        converted_char_t want;
        if (expected_chars.size() == 0) begin
            report("unexpected result out_char", 8'h00, ch);
            return;
        end
        want = expected_chars.pop_front();
        if (ch !== want.ch)
            report("out_char", want.ch, ch);
        if (bad !== want.bad)
            report("bad_input", 8'(want.bad), 8'(bad));
        if (fin !== want.fin)
            report("last_out", 8'(want.fin), 8'(fin));
    endfunction
endclass

module tb_radix_converter_with_fraction;

    localparam int ITEM_TARGET    = 460;
    localparam int WATCHDOG_LIMIT = 3000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    logic [CHAR_W-1:0] char_code = '0;
    logic              last_char = 1'b0;
    logic              strobe;
    logic [CHAR_W-1:0] out_char;
    logic              bad_input;
    logic              last_out;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = 1'b0;
    logic [BASE_W-1:0] cfg_data  = '0;

    radix_scoreboard   sb = new();
    logic [CHAR_W-1:0] char_seq[$];
    int                chars_sent   = 0;
    int                idle_pct     = 0;
    int                quiet_cycles = 0;

    radix_converter_with_fraction u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .char_code (char_code),
        .last_char (last_char),
        .strobe    (strobe),
        .out_char  (out_char),
        .bad_input (bad_input),
        .last_out  (last_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && strobe)
            sb.check_result(out_char, bad_input, last_out);
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || strobe || (start && !busy))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_radix_converter_with_fraction: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Start stays high after acceptance; the next call either raises it with
    // new data in the same step or one of the waits below lowers it.
    task automatic drive_char(input logic [CHAR_W-1:0] c, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        char_code <= c;
        last_char <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_char(c, last);
        chars_sent++;
    endtask

    task automatic wait_until_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [BASE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_register(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sequence(input bit allow_rebase);
        int rebase_at;
        rebase_at = -1;
        if (allow_rebase && char_seq.size() > 2 && $urandom_range(19) == 0)
            rebase_at = $urandom_range(1, char_seq.size() - 2);
        for (int i = 0; i < char_seq.size(); i++) begin
            // Source base changes between two characters of the same number.
            if (i == rebase_at) begin
                wait_until_quiet();
                write_reg(REG_SOURCE_BASE, BASE_W'($urandom_range(2, 16)));
            end
            drive_char(char_seq[i], i == char_seq.size() - 1);
        end
    endtask

    task automatic queue_text(input string s);
        char_seq.delete();
        for (int i = 0; i < s.len(); i++)
            char_seq.push_back(s[i]);
    endtask

    function automatic logic [CHAR_W-1:0] digit_code(input int value);
        if (value < 10)
            return CHAR_ZERO + CHAR_W'(value);
        return ($urandom_range(1) ? CHAR_LA : CHAR_UA) + CHAR_W'(value - 10);
    endfunction

    function automatic logic [CHAR_W-1:0] random_junk();
        case ($urandom_range(4))
            0: return CHAR_W'($urandom_range(255));
            1: return CHAR_DOT;
            2: return digit_code($urandom_range(15));
            3:
            begin
                // Codes just outside the digit and letter ranges.
                case ($urandom_range(5))
                    0: return CHAR_ZERO - 8'd1;
                    1: return CHAR_NINE + 8'd1;
                    2: return CHAR_UA - 8'd1;
                    3: return CHAR_UF + 8'd1;
                    4: return CHAR_LA - 8'd1;
                    default: return CHAR_LF + 8'd1;
                endcase
            end
            default: return CHAR_W'($urandom_range(128, 255));
        endcase
    endfunction

    task automatic build_number();
        int kind, total, int_len, radix, pos;
        radix = (sb.source_base >= BASE_MIN && sb.source_base <= BASE_MAX) ?
                int'(sb.source_base) : 16;
        char_seq.delete();
        kind = $urandom_range(99);
        if (kind < 80) begin
            total   = (kind < 8) ? $urandom_range(14, 16) : $urandom_range(1, 13);
            int_len = total;
            if (total >= 3 && $urandom_range(1))
                int_len = $urandom_range(1, total - 2);
            for (int i = 0; i < total; i++) begin
                if (i == int_len)
                    char_seq.push_back(CHAR_DOT);
                else
                    char_seq.push_back(digit_code($urandom_range(radix - 1)));
            end
            if (kind >= 70) begin
                pos = $urandom_range(total - 1);
                char_seq[pos] = random_junk();
            end
        end
        else begin
            total = $urandom_range(1, 16);
            for (int i = 0; i < total; i++)
                char_seq.push_back(random_junk());
        end
    endtask

    task automatic pick_bases();
        logic [BASE_W-1:0] src, tgt;
        int                r;
        r   = $urandom_range(99);
        src = BASE_W'($urandom_range(2, 16));
        tgt = BASE_W'($urandom_range(2, 16));
        if (r < 8) begin
            if ($urandom_range(1))
                src = $urandom_range(1) ? 5'd0 : ($urandom_range(1) ? 5'd31 : 5'd17);
            else
                tgt = $urandom_range(1) ? 5'd1 : ($urandom_range(1) ? 5'd31 : 5'd0);
        end
        else if (r < 35) begin
            src = $urandom_range(1) ? BASE_MIN : BASE_MAX;
            tgt = $urandom_range(1) ? BASE_MIN : BASE_MAX;
        end
        wait_until_quiet();
        write_reg(REG_SOURCE_BASE, src);
        write_reg(REG_TARGET_BASE, tgt);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases under the reset bases, ten to two.
        queue_text("7.5");
        send_sequence(0);
        drive_char(8'h00, 1'b1);
        queue_text(".5");
        send_sequence(0);
        queue_text("5.");
        send_sequence(0);
        queue_text("1..");
        send_sequence(0);
        queue_text("a");
        send_sequence(0);

        wait_until_quiet();
        write_reg(REG_SOURCE_BASE, BASE_MAX);
        queue_text("A.f");
        send_sequence(0);
        drive_char(8'hFF, 1'b1);

        wait_until_quiet();
        write_reg(REG_TARGET_BASE, 5'd10);
        drive_char("F", 1'b0);
        wait_until_quiet();
        write_reg(REG_SOURCE_BASE, BASE_MIN);
        drive_char("1", 1'b1);

        wait_until_quiet();
        write_reg(REG_TARGET_BASE, 5'd0);
        drive_char("1", 1'b1);
        wait_until_quiet();
        write_reg(REG_SOURCE_BASE, 5'd31);
        write_reg(REG_TARGET_BASE, 5'd31);
        drive_char("1", 1'b1);
        wait_until_quiet();
        write_reg(REG_SOURCE_BASE, BASE_MIN);
        write_reg(REG_TARGET_BASE, BASE_MAX);
        queue_text("1.1");
        send_sequence(0);

        // Random numbers in three pacing phases: light, heavy, then no gaps.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 25 : (phase == 1) ? 59 : 0;
            while (chars_sent < (phase + 1) * ITEM_TARGET / 3) begin
                pick_bases();
                repeat ($urandom_range(3, 8)) begin
                    build_number();
                    send_sequence(1);
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.failures == 0)
            $display("tb_radix_converter_with_fraction: PASS");
        else
            $display("tb_radix_converter_with_fraction: FAIL");
        $finish;
    end

endmodule
